[rtl/core/dtu_pkg.sv]
// ----------------------------------------------------------------------------
// dtu_pkg: shared types and constants for the date/epoch to Unix time block
// Item layout between the front end and the back end, register codes, status
// codes, reciprocal constants and the calendar tables.
// ----------------------------------------------------------------------------
package dtu_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MS_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE    = 2'd2;

	localparam logic [1:0] ZONE_OTHER = 2'd3;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CONFIG    = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;
	localparam logic [1:0] ST_BAD_DATE  = 2'd3;

	// input ranges
	localparam logic signed [63:0] DATEINT_THRESHOLD = 64'sd100000000;
	localparam logic signed [63:0] DATEINT_MIN       = 64'sd10000000;
	localparam logic signed [63:0] EPOCH_SECONDS_MAX = 64'sd99999999999;
	localparam logic signed [63:0] EPOCH_MILLIS_MAX  = 64'sd99999999999999;

	// exact reciprocals: floor(x * R >> k) == x / d over the stated input range
	localparam logic [27:0] RECIP_1E4 = 28'd219902326; // k = 41, x < 2**27
	localparam logic [26:0] RECIP_1E3 = 27'd68719477;  // k = 36, x < 2**26
	localparam logic [13:0] RECIP_100 = 14'd10486;     // k = 20, x < 2**14

	localparam logic [22:0] DAYS_TO_1970 = 23'd719468; // 0000-03-01 to 1970-01-01

	typedef struct packed {
		logic       ms_mode;
		logic       format_is_dash;
		logic [1:0] zone_kind;
	} dtu_cfg_t;

	typedef enum logic [2:0] {
		KIND_CFG_ERR   = 3'd0,
		KIND_TOO_LARGE = 3'd1,
		KIND_BAD_DATE  = 3'd2,
		KIND_EPOCH_S   = 3'd3,
		KIND_EPOCH_MS  = 3'd4,
		KIND_DATE      = 3'd5
	} dtu_kind_t;

	// value holds input bits 46:0; only the epoch and date kinds use it
	typedef struct packed {
		dtu_kind_t   kind;
		logic        ms_mode;
		logic [46:0] value;
	} dtu_item_t;

	function automatic logic [4:0] month_days(input logic [6:0] m);
		logic [4:0] r;
		case (m)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
			7'd2: r = 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// day of the year counted from March 1 for the first day of month m
	function automatic logic [8:0] doy_base(input logic [6:0] m);
		logic [8:0] r;
		case (m)
			7'd3:  r = 9'd0;
			7'd4:  r = 9'd31;
			7'd5:  r = 9'd61;
			7'd6:  r = 9'd92;
			7'd7:  r = 9'd122;
			7'd8:  r = 9'd153;
			7'd9:  r = 9'd184;
			7'd10: r = 9'd214;
			7'd11: r = 9'd245;
			7'd12: r = 9'd275;
			7'd1:  r = 9'd306;
			7'd2:  r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/dateint_or_epoch_to_unix_time.sv]
// ----------------------------------------------------------------------------
// dateint_or_epoch_to_unix_time: dateint or epoch value to Unix time
// Top level: configuration registers, front end, item queue, back end.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with input_value, a signed 64-bit
//   YYYYMMDD dateint or an epoch value (seconds up to 11 digits, millis for
//   12 to 14 digits). Output channel: out_valid / out_stall with unix_time
//   (seconds or millis, signed 49 bits) and status. One result per item.
//   Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   millisecond mode (0), dash format (1) or zone kind (2); other indexes
//   are dropped. Write config only while no item is in flight.
//   Throughput: one item per clock while out_stall is low. Path from
//   acceptance to out_valid: front register, queue slot, 7-stage back
//   end; the back end's reciprocal multipliers and the x86400 / x1000
//   scaling set the stage count.
//   Reset: config returns to seconds mode, dash format, UTC; all valids clear.
//   Stall: out_stall freezes the whole back end; the queue (QUEUE_DEPTH
//   items) and the front register keep accepting until full, then in_stall
//   rises.
// ----------------------------------------------------------------------------
module dateint_or_epoch_to_unix_time #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dtu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [63:0]              input_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [48:0]              unix_time,
	output logic [1:0]                      status
);
	import dtu_pkg::*;

	dtu_cfg_t  cfg_q;
	logic      q_full;
	logic      q_empty;
	logic      push;
	logic      pop;
	dtu_item_t push_item;
	dtu_item_t pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ms_mode        <= 1'b0;
			cfg_q.format_is_dash <= 1'b1;
			cfg_q.zone_kind      <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MS_MODE: cfg_q.ms_mode        <= cfg_data[0];
				REG_FORMAT:  cfg_q.format_is_dash <= cfg_data[0];
				REG_ZONE:    cfg_q.zone_kind      <= cfg_data[1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// front end: classify against the config, one register deep
	dtu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.input_value (input_value),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// queue lets the front keep taking items while the back end stalls
	dtu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	// back end: arithmetic pipeline ending in the output register
	dtu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.unix_time (unix_time),
		.status    (status)
	);

endmodule

[rtl/core/dtu_front.sv]
// ----------------------------------------------------------------------------
// dtu_front: input stage
// Accepts items, sorts each into error, epoch or dateint kinds and hands it
// to the queue.
// ----------------------------------------------------------------------------
module dtu_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dtu_pkg::dtu_cfg_t       cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [63:0]      input_value,
	input  logic                    q_full,
	output logic                    push,
	output dtu_pkg::dtu_item_t      push_item
);
	import dtu_pkg::*;

	logic      vld_s1;
	dtu_item_t item_s1;
	dtu_item_t item_d;
	logic      accept;
	logic      nonneg;
	logic      cfg_err;

	always_comb begin
		nonneg = !input_value[63];
		cfg_err = !cfg.format_is_dash || (cfg.zone_kind == ZONE_OTHER);
		item_d.ms_mode = cfg.ms_mode;
		item_d.value = input_value[46:0];
		if (cfg_err) begin
			item_d.kind = KIND_CFG_ERR;
		end else if (nonneg && input_value > DATEINT_THRESHOLD) begin
			if (input_value > EPOCH_MILLIS_MAX) begin
				item_d.kind = KIND_TOO_LARGE;
			end else if (input_value > EPOCH_SECONDS_MAX) begin
				item_d.kind = KIND_EPOCH_MS;
			end else begin
				item_d.kind = KIND_EPOCH_S;
			end
		end else if (!nonneg || input_value < DATEINT_MIN ||
				input_value == DATEINT_THRESHOLD) begin
			item_d.kind = KIND_BAD_DATE;
		end else begin
			item_d.kind = KIND_DATE;
		end
	end

	// register drains into the queue in the same cycle a new item lands
	assign push     = vld_s1 && !q_full;
	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

[rtl/core/dtu_queue.sv]
// ----------------------------------------------------------------------------
// dtu_queue: item queue between front and back end
// Small circular buffer; decouples input acceptance from back-end stalls.
// ----------------------------------------------------------------------------
module dtu_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dtu_pkg::dtu_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output dtu_pkg::dtu_item_t pop_item
);
	import dtu_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dtu_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");

endmodule

[rtl/core/dtu_back.sv]
// ----------------------------------------------------------------------------
// dtu_back: conversion pipeline
// Seven stages: digit split of the dateint, calendar checks, days-from-civil,
// scaling to seconds and milliseconds; epoch millis divided by 1000 in
// three radix-2**16 long-division steps alongside.
// ----------------------------------------------------------------------------
module dtu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  dtu_pkg::dtu_item_t pop_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [48:0] unix_time,
	output logic [1:0]         status
);
	import dtu_pkg::*;

	logic advance;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	dtu_kind_t kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic      ms_s1, ms_s2, ms_s3, ms_s4, ms_s5, ms_s6;
	logic [46:0] val_s1, val_s2, val_s3, val_s4, val_s5, val_s6;

	// stage 1: y = v / 10000, first division step on bits 46:32
	logic [54:0] prody_s1;
	logic [41:0] prod2_s1;

	// stage 2
	logic [13:0] y_b2;
	logic [26:0] rem_full_b2;
	logic [5:0]  q2_b2;
	logic [14:0] r2_full_b2;
	logic [13:0] y_s2, rem_s2;
	logic [5:0]  q2_s2;
	logic [25:0] x1_s2;

	// stage 3
	logic [27:0] prodm_s3, prodh_s3;
	logic [52:0] prod1_s3;
	logic [13:0] y_s3, rem_s3;
	logic [5:0]  q2_s3;
	logic [25:0] x1_s3;

	// stage 4
	logic [6:0]  m_b4, d_b4, yh_b4, yl_b4;
	logic [13:0] d_full_b4, yl_full_b4;
	logic [15:0] q1_b4;
	logic [25:0] r1_full_b4;
	logic        leap_b4, jan_feb_b4, month_ok_b4, day_ok_b4;
	logic [4:0]  dim_b4;
	logic [13:0] ay_s4;
	logic [6:0]  cent_s4;
	logic [8:0]  doy_s4;
	logic        date_ok_s4;
	logic [5:0]  q2_s4;
	logic [15:0] q1_s4;
	logic [25:0] x0_s4;

	// stage 5
	logic [22:0]        pos_b5;
	logic signed [22:0] days_b5;
	logic signed [22:0] days_s5;
	logic [52:0]        prod0_s5;
	logic [5:0]         q2_s5;
	logic [15:0]        q1_s5;
	logic               date_ok_s5;

	// stage 6
	logic signed [39:0] days_x_b6;
	logic signed [39:0] secs_s6;
	logic [37:0]        quot_s6;
	logic               date_ok_s6;

	// stage 7 (output register)
	logic signed [40:0] oper_b7;
	logic signed [50:0] oper_x_b7;
	logic signed [50:0] scaled_b7;
	logic [48:0]        time_b7;
	logic [1:0]         status_b7;
	logic signed [48:0] unix_time_s7;
	logic [1:0]         status_s7;

	// whole pipeline moves together; holds while the result waits
	assign advance   = !vld_s7 || !out_stall;
	assign pop       = advance && !q_empty;
	assign out_valid = vld_s7;
	assign unix_time = unix_time_s7;
	assign status    = status_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 2 logic: remainders from the reciprocal quotients
	always_comb begin
		y_b2 = prody_s1[54:41];
		rem_full_b2 = val_s1[26:0] - 27'(y_b2) * 27'd10000;
		q2_b2 = prod2_s1[41:36];
		r2_full_b2 = val_s1[46:32] - 15'(q2_b2) * 15'd1000;
	end

	// stage 4 logic: month, day, century split and calendar checks
	always_comb begin
		m_b4 = prodm_s3[26:20];
		d_full_b4 = rem_s3 - 14'(m_b4) * 14'd100;
		d_b4 = d_full_b4[6:0];
		yh_b4 = prodh_s3[26:20];
		yl_full_b4 = y_s3 - 14'(yh_b4) * 14'd100;
		yl_b4 = yl_full_b4[6:0];
		q1_b4 = prod1_s3[51:36];
		r1_full_b4 = x1_s3 - 26'(q1_b4) * 26'd1000;

		// y % 4 equals yl % 4; century years need yh % 4
		leap_b4 = (yl_b4 != '0) ? (yl_b4[1:0] == 2'd0) : (yh_b4[1:0] == 2'd0);
		month_ok_b4 = m_b4 inside {[7'd1:7'd12]};
		dim_b4 = (m_b4 == 7'd2 && leap_b4) ? 5'd29 : month_days(m_b4);
		day_ok_b4 = (d_b4 != '0) && (d_b4 <= 7'(dim_b4));
		jan_feb_b4 = (m_b4 <= 7'd2);
	end

	// stage 5 logic: days from civil without division
	// days = 365*ay + ay/4 - ay/100 + ay/400 + doy - 719468
	always_comb begin
		pos_b5 = 23'(ay_s4) * 23'd365 + 23'(ay_s4[13:2]) + 23'(cent_s4[6:2]) +
			23'(doy_s4);
		days_b5 = pos_b5 - 23'(cent_s4) - DAYS_TO_1970;
	end

	always_comb begin
		days_x_b6 = 40'(days_s5);
	end

	// stage 7 logic: one shared x1000 multiplier and the result select
	always_comb begin
		if (kind_s6 == KIND_DATE) begin
			oper_b7 = 41'(secs_s6);
		end else begin
			oper_b7 = {4'b0, val_s6[36:0]};
		end
		oper_x_b7 = 51'(oper_b7);
		scaled_b7 = oper_x_b7 * 51'sd1000;
		case (kind_s6)
			KIND_DATE: begin
				status_b7 = date_ok_s6 ? ST_OK : ST_BAD_DATE;
				if (!date_ok_s6) begin
					time_b7 = '0;
				end else if (ms_s6) begin
					time_b7 = scaled_b7[48:0];
				end else begin
					time_b7 = 49'(oper_b7);
				end
			end
			KIND_EPOCH_S: begin
				status_b7 = ST_OK;
				time_b7 = ms_s6 ? scaled_b7[48:0] : 49'(oper_b7);
			end
			KIND_EPOCH_MS: begin
				status_b7 = ST_OK;
				time_b7 = ms_s6 ? {2'b0, val_s6} : 49'(quot_s6);
			end
			KIND_TOO_LARGE: begin
				status_b7 = ST_TOO_LARGE;
				time_b7 = '0;
			end
			KIND_CFG_ERR: begin
				status_b7 = ST_CONFIG;
				time_b7 = '0;
			end
			default: begin
				status_b7 = ST_BAD_DATE;
				time_b7 = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// stage 1
			kind_s1  <= pop_item.kind;
			ms_s1    <= pop_item.ms_mode;
			val_s1   <= pop_item.value;
			prody_s1 <= 55'(pop_item.value[26:0]) * 55'(RECIP_1E4);
			prod2_s1 <= 42'(pop_item.value[46:32]) * 42'(RECIP_1E3);

			// stage 2
			kind_s2 <= kind_s1;
			ms_s2   <= ms_s1;
			val_s2  <= val_s1;
			y_s2    <= y_b2;
			rem_s2  <= rem_full_b2[13:0];
			q2_s2   <= q2_b2;
			x1_s2   <= {r2_full_b2[9:0], val_s1[31:16]};

			// stage 3
			kind_s3  <= kind_s2;
			ms_s3    <= ms_s2;
			val_s3   <= val_s2;
			prodm_s3 <= 28'(rem_s2) * 28'(RECIP_100);
			prodh_s3 <= 28'(y_s2) * 28'(RECIP_100);
			prod1_s3 <= 53'(x1_s2) * 53'(RECIP_1E3);
			y_s3     <= y_s2;
			rem_s3   <= rem_s2;
			q2_s3    <= q2_s2;
			x1_s3    <= x1_s2;

			// stage 4
			kind_s4    <= kind_s3;
			ms_s4      <= ms_s3;
			val_s4     <= val_s3;
			ay_s4      <= y_s3 - 14'(jan_feb_b4);
			cent_s4    <= (jan_feb_b4 && yl_b4 == '0) ? yh_b4 - 7'd1 : yh_b4;
			doy_s4     <= doy_base(m_b4) + 9'(d_b4) - 9'd1;
			date_ok_s4 <= month_ok_b4 && day_ok_b4;
			q2_s4      <= q2_s3;
			q1_s4      <= q1_b4;
			x0_s4      <= {r1_full_b4[9:0], val_s3[15:0]};

			// stage 5
			kind_s5    <= kind_s4;
			ms_s5      <= ms_s4;
			val_s5     <= val_s4;
			days_s5    <= days_b5;
			prod0_s5   <= 53'(x0_s4) * 53'(RECIP_1E3);
			q2_s5      <= q2_s4;
			q1_s5      <= q1_s4;
			date_ok_s5 <= date_ok_s4;

			// stage 6
			kind_s6    <= kind_s5;
			ms_s6      <= ms_s5;
			val_s6     <= val_s5;
			secs_s6    <= days_x_b6 * 40'sd86400;
			quot_s6    <= {q2_s5, q1_s5, prod0_s5[51:36]};
			date_ok_s6 <= date_ok_s5;

			// stage 7
			unix_time_s7 <= time_b7;
			status_s7    <= status_b7;
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> unix_time == '0)
		else $error("nonzero time on an error result");

endmodule
